// ----- hw/rtl/wbmp_pkg.sv -----
// Shared constants, phase codes and types for the WBMP stream parser.
`timescale 1ns / 1ps

package wbmp_pkg;

  // Width in bits of the width and height values that the parser accepts.
  localparam int unsigned DIM_BITS = 16;

  // Pixels carried by one data byte.
  localparam int unsigned PIX_PER_BYTE = 8;

  // Parse phase codes.
  localparam logic [3:0] PH_TYPE   = 4'd0;
  localparam logic [3:0] PH_FIXHDR = 4'd1;
  localparam logic [3:0] PH_EXT0   = 4'd2;
  localparam logic [3:0] PH_PAIR   = 4'd3;
  localparam logic [3:0] PH_SKIP   = 4'd4;
  localparam logic [3:0] PH_WIDTH  = 4'd5;
  localparam logic [3:0] PH_HEIGHT = 4'd6;
  localparam logic [3:0] PH_PIXELS = 4'd7;
  localparam logic [3:0] PH_DONE   = 4'd8;
  localparam logic [3:0] PH_DRAIN  = 4'd9;

  // Extension header types in bits 6..5 of the fixed header byte.
  localparam logic [1:0] EXT_MBI  = 2'd0;
  localparam logic [1:0] EXT_PAIR = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_PIXELS = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_BAD_EXT   = 2'd0;
  localparam logic [1:0] ERR_LEVEL     = 2'd1;
  localparam logic [1:0] ERR_DIM       = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    logic [3:0]          phase;
    logic [DIM_BITS-1:0] acc;
    logic                level_nz;
    logic [4:0]          skip;
    logic                more_pairs;
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    logic [DIM_BITS-1:0] column;
    logic [DIM_BITS-1:0] row;
  } state_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  pixel_bits;
    logic [3:0]  pixel_count;
    logic        row_end;
    logic        image_end;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  error_code;
  } result_t;

endpackage

// ----- hw/rtl/wbmp_if.sv -----
// Valid/ready channel interfaces for the WBMP byte input and the result output.
`timescale 1ns / 1ps

interface wbmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbmp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  pixel_bits;
  logic [3:0]  pixel_count;
  logic        row_end;
  logic        image_end;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [1:0]  error_code;

  modport source (output valid, output result_kind, output pixel_bits,
                  output pixel_count, output row_end, output image_end,
                  output image_width, output image_height, output error_code,
                  input ready);
  modport sink   (input valid, input result_kind, input pixel_bits,
                  input pixel_count, input row_end, input image_end,
                  input image_width, input image_height, input error_code,
                  output ready);
endinterface

// ----- hw/rtl/wbmp_step.sv -----
// Next-state and result logic of the WBMP parser for one input byte.
`timescale 1ns / 1ps

module wbmp_step (
  input  wbmp_pkg::state_t  cur,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output wbmp_pkg::state_t  nxt,
  output logic              have,
  output wbmp_pkg::result_t res
);

  localparam int unsigned D = wbmp_pkg::DIM_BITS;

  logic         err;
  logic [1:0]   err_code;
  logic         complete;
  logic [4:0]   pair_sum;
  logic [4:0]   skip_dec;
  logic [D-1:0] acc_new;
  logic [D-1:0] rem;
  logic [3:0]   cnt;
  logic [D-1:0] col_new;
  logic [D-1:0] row_new;

  // Datapath terms used by several phases.
  always_comb begin
    pair_sum = {2'b00, data_byte[6:4]} + {1'b0, data_byte[3:0]};
    skip_dec = (cur.skip != 5'd0) ? cur.skip - 5'd1 : 5'd0;
    acc_new  = {cur.acc[D-8:0], data_byte[6:0]};
    rem      = cur.width - cur.column;
    if (rem >= D'(wbmp_pkg::PIX_PER_BYTE)) begin
      cnt = 4'(wbmp_pkg::PIX_PER_BYTE);
    end else begin
      cnt = rem[3:0];
    end
    if (cnt == 4'd0) begin
      cnt = 4'd1;
    end
    col_new = cur.column + D'(cnt);
    row_new = cur.row + D'(1);
  end

  // Phase sequencing and result formation.
  always_comb begin
    nxt      = cur;
    res      = '0;
    have     = 1'b0;
    err      = 1'b0;
    err_code = wbmp_pkg::ERR_BAD_EXT;
    complete = 1'b0;

    case (cur.phase)
      wbmp_pkg::PH_TYPE: begin
        if (data_byte[6:0] != 7'd0) begin
          nxt.level_nz = 1'b1;
        end
        if (!data_byte[7]) begin
          nxt.phase = wbmp_pkg::PH_FIXHDR;
        end
      end
      wbmp_pkg::PH_FIXHDR: begin
        if (!data_byte[7]) begin
          nxt.phase = wbmp_pkg::PH_WIDTH;
        end else if (data_byte[6:5] == wbmp_pkg::EXT_MBI) begin
          nxt.phase = wbmp_pkg::PH_EXT0;
        end else if (data_byte[6:5] == wbmp_pkg::EXT_PAIR) begin
          nxt.phase = wbmp_pkg::PH_PAIR;
        end else begin
          err      = 1'b1;
          err_code = wbmp_pkg::ERR_BAD_EXT;
        end
      end
      wbmp_pkg::PH_EXT0: begin
        if (!data_byte[7]) begin
          nxt.phase = wbmp_pkg::PH_WIDTH;
        end
      end
      wbmp_pkg::PH_PAIR: begin
        nxt.skip       = pair_sum;
        nxt.more_pairs = data_byte[7];
        if (pair_sum == 5'd0) begin
          nxt.phase = data_byte[7] ? wbmp_pkg::PH_PAIR : wbmp_pkg::PH_WIDTH;
        end else begin
          nxt.phase = wbmp_pkg::PH_SKIP;
        end
      end
      wbmp_pkg::PH_SKIP: begin
        nxt.skip = skip_dec;
        if (skip_dec == 5'd0) begin
          nxt.phase = cur.more_pairs ? wbmp_pkg::PH_PAIR : wbmp_pkg::PH_WIDTH;
        end
      end
      wbmp_pkg::PH_WIDTH, wbmp_pkg::PH_HEIGHT: begin
        if (cur.acc[D-1:D-7] != 7'd0) begin
          // Another group would not fit in the dimension register.
          err      = 1'b1;
          err_code = wbmp_pkg::ERR_DIM;
        end else begin
          nxt.acc = acc_new;
          if (!data_byte[7]) begin
            nxt.acc = '0;
            if (cur.phase == wbmp_pkg::PH_WIDTH) begin
              nxt.width = acc_new;
              nxt.phase = wbmp_pkg::PH_HEIGHT;
            end else begin
              nxt.height = acc_new;
              if (cur.level_nz) begin
                err      = 1'b1;
                err_code = wbmp_pkg::ERR_LEVEL;
              end else begin
                res.result_kind  = wbmp_pkg::KIND_HEADER;
                res.image_width  = 16'(cur.width);
                res.image_height = 16'(acc_new);
                have             = 1'b1;
                nxt.column       = '0;
                nxt.row          = '0;
                if (cur.width == '0 || acc_new == '0) begin
                  // Empty image: no pixel bytes follow.
                  res.image_end = 1'b1;
                  complete      = 1'b1;
                  nxt.phase     = wbmp_pkg::PH_DONE;
                end else begin
                  nxt.phase = wbmp_pkg::PH_PIXELS;
                end
              end
            end
          end
        end
      end
      wbmp_pkg::PH_PIXELS: begin
        res.result_kind = wbmp_pkg::KIND_PIXELS;
        res.pixel_bits  = data_byte & (8'hFF << (4'd8 - cnt));
        res.pixel_count = cnt;
        have            = 1'b1;
        nxt.column      = col_new;
        if (col_new >= cur.width) begin
          res.row_end = 1'b1;
          nxt.column  = '0;
          nxt.row     = row_new;
          if (row_new >= cur.height) begin
            res.image_end = 1'b1;
            complete      = 1'b1;
            nxt.phase     = wbmp_pkg::PH_DONE;
          end
        end
      end
      wbmp_pkg::PH_DONE: begin
        nxt.phase = wbmp_pkg::PH_DONE;
      end
      default: begin
        nxt.phase = wbmp_pkg::PH_DRAIN;
      end
    endcase

    // An error replaces any other result and drains to the last byte.
    if (err) begin
      res             = '0;
      res.result_kind = wbmp_pkg::KIND_ERROR;
      res.error_code  = err_code;
      have            = 1'b1;
      nxt.phase       = wbmp_pkg::PH_DRAIN;
    end

    // The last byte ends the file; an unfinished image reports truncation.
    if (last_byte) begin
      if (!err && !complete && cur.phase <= wbmp_pkg::PH_PIXELS) begin
        res             = '0;
        res.result_kind = wbmp_pkg::KIND_ERROR;
        res.error_code  = wbmp_pkg::ERR_TRUNCATED;
        have            = 1'b1;
      end
      nxt       = '0;
      nxt.phase = wbmp_pkg::PH_TYPE;
    end
  end

endmodule

// ----- hw/rtl/wbmp_stream_parser_unit.sv -----
// Top level of the WBMP stream parser: input register, parser state and result register.
`timescale 1ns / 1ps

// Channel   | Direction | Request
// ----------+-----------+--------------------------------------------------
// in_ch     | sink      | one file byte with a last-byte flag
// out_ch    | source    | pixel group, header dimensions or error
//
// The parser takes one byte per cycle while the result register can take its
// result; a byte's result, if it has one, passes the input register, then the result register.
// Parsing for each byte is a single pass of small logic on the parser state.
// Reset is synchronous and returns the parser to the type field.
// When the result register is full and not taken, the held byte waits in the
// input register and in_ch.ready drops once that register is occupied too.

module wbmp_stream_parser_unit (
  input  logic              clk,
  input  logic              rst_n,
  wbmp_in_if.sink           in_ch,
  wbmp_out_if.source        out_ch
);

  logic                 in_v_r;
  logic [7:0]           in_byte_r;
  logic                 in_last_r;
  wbmp_pkg::state_t     state_r;
  wbmp_pkg::state_t     state_nxt;
  logic                 out_v_r;
  wbmp_pkg::result_t    out_r;
  logic                 step_have;
  wbmp_pkg::result_t    step_res;
  logic                 advance;

  // The held byte is processed when the result register can take its result.
  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;

  wbmp_step u_step (
    .cur       (state_r),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .nxt       (state_nxt),
    .have      (step_have),
    .res       (step_res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.data_byte;
      in_last_r <= in_ch.last_byte;
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= '0;
      state_r.phase <= wbmp_pkg::PH_TYPE;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= step_have;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_have) begin
      out_r <= step_res;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.result_kind  = out_r.result_kind;
  assign out_ch.pixel_bits   = out_r.pixel_bits;
  assign out_ch.pixel_count  = out_r.pixel_count;
  assign out_ch.row_end      = out_r.row_end;
  assign out_ch.image_end    = out_r.image_end;
  assign out_ch.image_width  = out_r.image_width;
  assign out_ch.image_height = out_r.image_height;
  assign out_ch.error_code   = out_r.error_code;

endmodule

// ----- hw/rtl/wbmp_chk.sv -----
// Port-level checker for the WBMP stream parser and its bind to the top level.
`timescale 1ns / 1ps

module wbmp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_result_kind,
  input logic [7:0]  out_pixel_bits,
  input logic [3:0]  out_pixel_count,
  input logic        out_row_end,
  input logic        out_image_end,
  input logic [15:0] out_image_width,
  input logic [15:0] out_image_height,
  input logic [1:0]  out_error_code
);

  // A stalled result keeps its kind, pixel bits and count, error code and width on the port.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
      $stable(out_pixel_bits) && $stable(out_pixel_count) &&
      $stable(out_error_code) && $stable(out_image_width))
    else $error("result changed while stalled");

  // A pixel group carries one to eight pixels, and ends a row if it ends the image.
  a_pix_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == wbmp_pkg::KIND_PIXELS |->
      out_pixel_count != 4'd0 && out_pixel_count <= 4'd8 &&
      (!out_image_end || out_row_end))
    else $error("malformed pixel group");

  // A header marks the image complete exactly when it is empty.
  a_hdr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == wbmp_pkg::KIND_HEADER |->
      out_image_end == (out_image_width == 16'd0 || out_image_height == 16'd0))
    else $error("header image_end does not match its dimensions");

  // Error results carry only their code, and no kind beyond error is used.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind <= wbmp_pkg::KIND_ERROR &&
      (out_result_kind != wbmp_pkg::KIND_ERROR ||
       (out_pixel_bits == 8'd0 && out_pixel_count == 4'd0 && !out_row_end &&
        !out_image_end && out_image_width == 16'd0 && out_image_height == 16'd0)))
    else $error("error result carries stray fields");

endmodule

bind wbmp_stream_parser_unit wbmp_chk u_wbmp_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_kind  (out_ch.result_kind),
  .out_pixel_bits   (out_ch.pixel_bits),
  .out_pixel_count  (out_ch.pixel_count),
  .out_row_end      (out_ch.row_end),
  .out_image_end    (out_ch.image_end),
  .out_image_width  (out_ch.image_width),
  .out_image_height (out_ch.image_height),
  .out_error_code   (out_ch.error_code)
);
